// ===== design/sccf_pkg.sv =====
// Shared types and constants of the CRC frame checker.
`timescale 1ns / 1ps
`default_nettype none

package sccf_pkg;

   localparam logic [7:0]  FRAME_LEN_RESET = 8'd32;
   localparam logic [7:0]  MIN_FRAME_LEN   = 8'd5;
   localparam logic [15:0] CRC_POLY        = 16'h1021;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef enum logic [1:0] {
      STATUS_BUSY    = 2'd0,
      STATUS_OK      = 2'd1,
      STATUS_CRC_ERR = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic [7:0] byte_index;
      logic       last_of_frame;
      status_type frame_status;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

endpackage

`default_nettype wire

// ===== design/sccf_crc_unit.sv =====
// Byte-wide CRC-16 update, polynomial 0x1021, most significant bit first.
`timescale 1ns / 1ps
`default_nettype none

module sccf_crc_unit (
   input  wire logic [15:0] crc,
   input  wire logic [7:0]  data,
   output logic [15:0]      crc_next
);
   import sccf_pkg::*;

   always_comb begin
      logic [15:0] acc;
      acc = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (acc[15]) begin
            acc = {acc[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            acc = {acc[14:0], 1'b0};
         end
      end
      crc_next = acc;
   end

endmodule

`default_nettype wire

// ===== design/sccf_frame_ctrl.sv =====
// Input register, header hunt, frame counter and CRC check of the frame checker.
`timescale 1ns / 1ps
`default_nettype none

module sccf_frame_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [7:0]       csr_frame_length,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic             room,
   output sccf_pkg::push_type    push
);
   import sccf_pkg::*;

   logic [7:0]  len_ff, len_in;
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   logic        in_frame_ff, in_frame_in;
   logic        prev_valid_ff, prev_valid_in;
   logic [7:0]  prev_byte_ff, prev_byte_in;
   logic [7:0]  byte_count_ff, byte_count_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  rx_low_ff, rx_low_in;
   logic [15:0] crc_upd;
   logic [7:0]  len_eff, last_idx, crc_idx;
   logic        consume;

   sccf_crc_unit u_crc (
      .crc      (crc_ff),
      .data     (in_byte_ff),
      .crc_next (crc_upd)
   );

   assign csr_ready = 1'b1;
   assign consume   = in_valid_ff && room;
   assign req_ready = !in_valid_ff || room;
   assign len_eff   = (len_ff < MIN_FRAME_LEN) ? MIN_FRAME_LEN : len_ff;
   assign last_idx  = len_eff - 8'd1;
   assign crc_idx   = len_eff - 8'd2;

   always_comb begin
      len_in        = (csr_valid && csr_ready) ? csr_frame_length : len_ff;
      in_byte_in    = (req_valid && req_ready) ? req_data_byte : in_byte_ff;
      in_valid_in   = (req_valid && req_ready) ? 1'b1 : (consume ? 1'b0 : in_valid_ff);
      in_frame_in   = in_frame_ff;
      prev_valid_in = prev_valid_ff;
      prev_byte_in  = prev_byte_ff;
      byte_count_in = byte_count_ff;
      crc_in        = crc_ff;
      rx_low_in     = rx_low_ff;
      push          = '0;
      if (consume) begin
         if (!in_frame_ff) begin
            if (prev_valid_ff && (prev_byte_ff == ~in_byte_ff)) begin
               push.count  = 2'd2;
               push.first  = '{frame_byte: prev_byte_ff, byte_index: 8'd0,
                               last_of_frame: 1'b0, frame_status: STATUS_BUSY};
               push.second = '{frame_byte: in_byte_ff, byte_index: 8'd1,
                               last_of_frame: 1'b0, frame_status: STATUS_BUSY};
               in_frame_in   = 1'b1;
               prev_valid_in = 1'b0;
               byte_count_in = 8'd2;
               crc_in        = '0;
            end else begin
               prev_byte_in  = in_byte_ff;
               prev_valid_in = 1'b1;
            end
         end else if (byte_count_ff >= last_idx) begin
            push.count = 2'd1;
            push.first = '{frame_byte: in_byte_ff, byte_index: byte_count_ff,
                           last_of_frame: 1'b1,
                           frame_status: (crc_ff == {in_byte_ff, rx_low_ff}) ?
                                         STATUS_OK : STATUS_CRC_ERR};
            in_frame_in   = 1'b0;
            prev_valid_in = 1'b0;
            byte_count_in = '0;
         end else begin
            if (byte_count_ff == crc_idx) begin
               rx_low_in = in_byte_ff;
            end else begin
               crc_in = crc_upd;
            end
            push.count = 2'd1;
            push.first = '{frame_byte: in_byte_ff, byte_index: byte_count_ff,
                           last_of_frame: 1'b0, frame_status: STATUS_BUSY};
            byte_count_in = byte_count_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff   <= in_byte_in;
      prev_byte_ff <= prev_byte_in;
      if (reset) begin
         len_ff        <= FRAME_LEN_RESET;
         in_valid_ff   <= 1'b0;
         in_frame_ff   <= 1'b0;
         prev_valid_ff <= 1'b0;
         byte_count_ff <= '0;
         crc_ff        <= '0;
         rx_low_ff     <= '0;
      end else begin
         len_ff        <= len_in;
         in_valid_ff   <= in_valid_in;
         in_frame_ff   <= in_frame_in;
         prev_valid_ff <= prev_valid_in;
         byte_count_ff <= byte_count_in;
         crc_ff        <= crc_in;
         rx_low_ff     <= rx_low_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/sccf_rsp_queue.sv =====
// Small result queue that takes up to two beats per cycle and hands out one per cycle while rsp_ready is high.
`timescale 1ns / 1ps
`default_nettype none

module sccf_rsp_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sccf_pkg::push_type    push,
   output logic                       room,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output sccf_pkg::rsp_item_type     rsp_item
);
   import sccf_pkg::*;

   rsp_item_type        entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]  head_ff, head_in;
   logic [Q_PTR_W-1:0]  tail_ff, tail_in;
   logic [Q_CNT_W-1:0]  count_ff, count_in;
   logic [Q_PTR_W-1:0]  tail_next;
   logic                pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = entry_ff[head_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign room      = (count_ff <= Q_CNT_W'(Q_DEPTH - 2));
   assign tail_next = tail_ff + 1'b1;

   always_comb begin
      head_in  = pop ? head_ff + 1'b1 : head_ff;
      tail_in  = tail_ff + Q_PTR_W'(push.count);
      count_in = count_ff + Q_CNT_W'(push.count) - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[tail_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[tail_next] <= push.second;
      end
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/sync_crc_frame_checker_top.sv =====
// Top level of the byte-stream frame hunter and CRC-16 checker.
// The block takes one byte per cycle on the req channel and sustains that rate as long
// as the rsp side keeps up. A byte is held in an input register; once the queue has room,
// its results, if any, are written into a four-entry result queue, whose first entry is
// offered on rsp. The byte that completes a header produces two beats (indices 0 and 1),
// which leave the queue one at a time, so the queue absorbs them and req_ready drops
// only when the queue has room for fewer than two more beats.
// The CRC-16 (polynomial 0x1021, zero start, equal to XMODEM) advances one byte per cycle while the queue has room.
`timescale 1ns / 1ps
`default_nettype none

module sync_crc_frame_checker_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_frame_length,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_frame_byte,
   output logic [7:0]      rsp_byte_index,
   output logic            rsp_last_of_frame,
   output logic [1:0]      rsp_frame_status
);
   import sccf_pkg::*;

   push_type     push;
   logic         room;
   rsp_item_type rsp_item;

   sccf_frame_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_frame_length (csr_frame_length),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .room             (room),
      .push             (push)
   );

   sccf_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_frame_byte    = rsp_item.frame_byte;
   assign rsp_byte_index    = rsp_item.byte_index;
   assign rsp_last_of_frame = rsp_item.last_of_frame;
   assign rsp_frame_status  = rsp_item.frame_status;

   // A beat that closes a frame carries a verdict, and no other beat does.
   a_last_has_status : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_frame |-> rsp_frame_status != STATUS_BUSY)
      else $error("last beat without CRC verdict");

   a_mid_no_status : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_frame |-> rsp_frame_status == STATUS_BUSY)
      else $error("verdict on a beat inside a frame");

   a_header_not_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_byte_index == 8'd0 || rsp_byte_index == 8'd1)
      |-> !rsp_last_of_frame)
      else $error("header beat marked as end of frame");

   a_two_beat_room : assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> room)
      else $error("header pushed into a queue without room");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the CRC-16 frame checker: directed table, random frames, scoreboard.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

   import sccf_pkg::*;

   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 80;
   localparam int MAX_REPORTS  = 100;
   localparam int PHASE_COUNT  = 12;

   typedef enum logic {ROW_DATA, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   value;
      logic         has_beat;
      rsp_item_type beat;
   } directed_row_type;

   localparam rsp_item_type NO_BEAT = '{frame_byte: 8'h00, byte_index: 8'h00,
                                        last_of_frame: 1'b0, frame_status: STATUS_BUSY};

   localparam directed_row_type DIRECTED_ROWS [24] = '{
      '{ROW_DATA, 8'hFF, 1'b0, NO_BEAT},
      '{ROW_DATA, 8'h00, 1'b1, '{8'h00, 8'd1, 1'b0, STATUS_BUSY}},
      '{ROW_DATA, 8'h12, 1'b0, NO_BEAT},
      '{ROW_DATA, 8'h34, 1'b0, NO_BEAT},
      '{ROW_DATA, 8'h56, 1'b1, '{8'h56, 8'd4, 1'b0, STATUS_BUSY}},
      '{ROW_CSR,  8'd5,  1'b0, NO_BEAT},
      '{ROW_DATA, 8'h78, 1'b0, NO_BEAT},
      '{ROW_DATA, 8'h00, 1'b0, NO_BEAT},
      '{ROW_DATA, 8'hFF, 1'b0, NO_BEAT},
      '{ROW_DATA, 8'h00, 1'b0, NO_BEAT},
      '{ROW_DATA, 8'h00, 1'b0, NO_BEAT},
      '{ROW_DATA, 8'h00, 1'b1, '{8'h00, 8'd4, 1'b1, STATUS_OK}},
      '{ROW_DATA, 8'hFF, 1'b0, NO_BEAT},
      '{ROW_DATA, 8'h80, 1'b0, NO_BEAT},
      '{ROW_DATA, 8'h7F, 1'b0, NO_BEAT},
      '{ROW_DATA, 8'h00, 1'b0, NO_BEAT},
      '{ROW_DATA, 8'h01, 1'b0, NO_BEAT},
      '{ROW_DATA, 8'h00, 1'b1, '{8'h00, 8'd4, 1'b1, STATUS_CRC_ERR}},
      '{ROW_CSR,  8'd0,  1'b0, NO_BEAT},
      '{ROW_DATA, 8'h0F, 1'b0, NO_BEAT},
      '{ROW_DATA, 8'hF0, 1'b0, NO_BEAT},
      '{ROW_DATA, 8'hFF, 1'b0, NO_BEAT},
      '{ROW_DATA, 8'h3C, 1'b0, NO_BEAT},
      '{ROW_DATA, 8'hA5, 1'b0, NO_BEAT}
   };

   localparam logic [7:0] PHASE_LENGTHS [PHASE_COUNT] = '{
      8'd5, 8'd6, 8'd0, 8'd17, 8'd255, 8'd1, 8'd32, 8'd9, 8'd100, 8'd5, 8'd12, 8'd40
   };

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       csr_valid        = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_frame_length = 8'd0;
   logic       req_valid        = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte    = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready        = 1'b0;
   logic [7:0] rsp_frame_byte;
   logic [7:0] rsp_byte_index;
   logic       rsp_last_of_frame;
   logic [1:0] rsp_frame_status;

   // Predictor state.
   logic [7:0]  frame_len_reg  = FRAME_LEN_RESET;
   logic        hunt_in_frame  = 1'b0;
   logic        hunt_prev_ok   = 1'b0;
   logic [7:0]  hunt_prev_byte = 8'd0;
   logic [7:0]  frame_count    = 8'd0;
   logic [15:0] frame_crc      = 16'd0;
   logic [7:0]  crc_low_seen   = 8'd0;

   rsp_item_type frame_beats_due[$];

   int fail_count      = 0;
   int send_idle_pct   = 0;
   int rsp_stall_pct   = 0;
   int holds_requested = 0;
   int holds_served    = 0;
   int hold_left       = 0;

   sync_crc_frame_checker_top uut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_frame_length  (csr_frame_length),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_frame_status  (rsp_frame_status)
   );

   always #5 clock = ~clock;

   function automatic logic [15:0] crc16_shift_byte(input logic [15:0] crc, input logic [7:0] d);
      logic top;
      for (int i = 7; i >= 0; i--) begin
         top = crc[15];
         crc = {crc[14:0], d[i]};
         if (top) crc = crc ^ CRC_POLY;
      end
      return crc;
   endfunction

   function automatic logic [7:0] effective_length(input logic [7:0] len);
      return (len < MIN_FRAME_LEN) ? MIN_FRAME_LEN : len;
   endfunction

   function automatic void predict_frame_beats(input logic [7:0] b);
      logic [7:0]  len;
      logic [15:0] crc;
      rsp_item_type beat;
      len = effective_length(frame_len_reg);
      if (!hunt_in_frame) begin
         if (hunt_prev_ok && hunt_prev_byte == ~b) begin
            frame_beats_due.push_back('{hunt_prev_byte, 8'd0, 1'b0, STATUS_BUSY});
            frame_beats_due.push_back('{b, 8'd1, 1'b0, STATUS_BUSY});
            hunt_in_frame = 1'b1;
            hunt_prev_ok  = 1'b0;
            frame_count   = 8'd2;
            frame_crc     = 16'd0;
         end else begin
            hunt_prev_byte = b;
            hunt_prev_ok   = 1'b1;
         end
      end else if (frame_count >= len - 8'd1) begin
         crc  = crc16_shift_byte(crc16_shift_byte(frame_crc, 8'd0), 8'd0);
         beat = '{b, frame_count, 1'b1, (crc == {b, crc_low_seen}) ? STATUS_OK : STATUS_CRC_ERR};
         frame_beats_due.push_back(beat);
         hunt_in_frame = 1'b0;
         hunt_prev_ok  = 1'b0;
         frame_count   = 8'd0;
      end else begin
         if (frame_count == len - 8'd2) crc_low_seen = b;
         else frame_crc = crc16_shift_byte(frame_crc, b);
         frame_beats_due.push_back('{b, frame_count, 1'b0, STATUS_BUSY});
         frame_count = frame_count + 8'd1;
      end
   endfunction

   task automatic send_data_byte(input logic [7:0] b, input logic has_beat,
                                 input rsp_item_type beat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_frame_beats(b);
      if (has_beat) frame_beats_due[$] = beat;
      @(negedge clock);
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (frame_beats_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_frame_length(input logic [7:0] len);
      wait_results_drained();
      csr_valid        <= 1'b1;
      csr_frame_length <= len;
      do @(posedge clock); while (csr_ready !== 1'b1);
      frame_len_reg = len;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random_phase(input logic [7:0] len, input int idle_pct,
                                   input int stall_pct, input int byte_target,
                                   input logic with_hold);
      int          sent;
      int          body_len;
      logic [7:0]  eff;
      logic [7:0]  head;
      logic [7:0]  b;
      logic [15:0] crc;
      write_frame_length(len);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      if (with_hold) holds_requested++;
      eff  = effective_length(len);
      sent = 0;
      while (sent < byte_target) begin
         repeat ($urandom_range(2)) send_data_byte(8'($urandom_range(255)), 1'b0, NO_BEAT);
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(6, 1)) send_data_byte(8'($urandom_range(255)), 1'b0, NO_BEAT);
         end else begin
            head = 8'($urandom_range(255));
            send_data_byte(head, 1'b0, NO_BEAT);
            send_data_byte(~head, 1'b0, NO_BEAT);
            sent += 2;
            body_len = int'(eff) - 4;
            // An occasional truncated frame makes the block swallow the next header.
            if ($urandom_range(11) == 0) body_len = $urandom_range(body_len);
            crc = 16'd0;
            for (int i = 0; i < body_len; i++) begin
               b   = 8'($urandom_range(255));
               crc = crc16_shift_byte(crc, b);
               send_data_byte(b, 1'b0, NO_BEAT);
               sent++;
            end
            if (body_len == int'(eff) - 4) begin
               crc = crc16_shift_byte(crc16_shift_byte(crc, 8'd0), 8'd0);
               if ($urandom_range(3) == 0) crc = crc ^ (16'h0001 << $urandom_range(15));
               send_data_byte(crc[7:0], 1'b0, NO_BEAT);
               send_data_byte(crc[15:8], 1'b0, NO_BEAT);
               sent += 2;
            end
         end
      end
   endtask

   always @(negedge clock) begin
      if (holds_served != holds_requested) begin
         holds_served++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (frame_beats_due.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("%0t: unexpected beat: got byte %02h index %0d last %0b status %0d",
                        $time, rsp_frame_byte, rsp_byte_index, rsp_last_of_frame,
                        rsp_frame_status);
         end else begin
            want = frame_beats_due.pop_front();
            if (rsp_frame_byte !== want.frame_byte || rsp_byte_index !== want.byte_index ||
                rsp_last_of_frame !== want.last_of_frame ||
                rsp_frame_status !== want.frame_status) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display({"%0t: beat mismatch: expected byte %02h index %0d last %0b ",
                            "status %0d, got byte %02h index %0d last %0b status %0d"},
                           $time, want.frame_byte, want.byte_index, want.last_of_frame,
                           want.frame_status, rsp_frame_byte, rsp_byte_index,
                           rsp_last_of_frame, rsp_frame_status);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("** sync_crc_frame_checker_top: FAILED **");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED_ROWS[r]) begin
         if (DIRECTED_ROWS[r].kind == ROW_CSR)
            write_frame_length(DIRECTED_ROWS[r].value);
         else
            send_data_byte(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].has_beat,
                           DIRECTED_ROWS[r].beat);
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p % 4)
            0: run_random_phase(PHASE_LENGTHS[p], 0, 0, 48, p == 0);
            1: run_random_phase(PHASE_LENGTHS[p], 46, 0, 48, 1'b0);
            2: run_random_phase(PHASE_LENGTHS[p], 0, 46, 48, 1'b0);
            default: run_random_phase(PHASE_LENGTHS[p], 37, 37, 48, 1'b0);
         endcase
      end

      req_valid <= 1'b0;
      while (frame_beats_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("** sync_crc_frame_checker_top: PASSED **");
      end else begin
         $display("** sync_crc_frame_checker_top: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
design/sccf_pkg.sv
design/sccf_crc_unit.sv
design/sccf_frame_ctrl.sv
design/sccf_rsp_queue.sv
design/sync_crc_frame_checker_top.sv
verif/tb_top.sv
